// ===== design/goldbach_prime_pair_finder_macros.svh =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder: assertion macros
// Shared property forms; the using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef GOLDBACH_PRIME_PAIR_FINDER_MACROS_SVH
`define GOLDBACH_PRIME_PAIR_FINDER_MACROS_SVH

// same-cycle implication
`define GPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define GPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== design/gpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gpf_pkg
// Widths, microcode types and status bundle of the prime pair finder.
// ----------------------------------------------------------------------------
package gpf_pkg;

	localparam int VALUE_WIDTH = 16;   // low target bits used by the search
	localparam int FIELD_WIDTH = 16;   // width of target and result ports
	localparam int UPC_W       = 5;    // microprogram counter width

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_IN,     // offer in_ready, capture a request
		OP_P_INIT,      // p = 2
		OP_P_INC,       // p = p + 1
		OP_N_FROM_P,    // test p next
		OP_N_FROM_Q,    // test target - p next
		OP_D_INIT,      // d = 3
		OP_D_ADD2,      // d = d + 2
		OP_SQ_CALC,     // sq = d * d
		OP_DIV_START,   // start n % d
		OP_POST_FOUND,  // load result register with the pair
		OP_POST_NONE    // load result register with no pair
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_T_ODD,
		C_P_GT_HALF,
		C_N_IS2,
		C_N_BAD,
		C_SQ_GT_N,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_PHASE,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		logic in_valid;
		logic t_odd;
		logic p_gt_half;
		logic n_is2;
		logic n_bad;
		logic sq_gt_n;
		logic div_busy;
		logic rem_zero;
		logic phase;
		logic out_full;
	} status_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] jump;
	} ucode_t;

endpackage

// ===== design/gpf_rem_unit.sv =====
// ----------------------------------------------------------------------------
// gpf_rem_unit
// Restoring remainder unit: one dividend bit per cycle, over all VALUE_WIDTH bits of the dividend.
// ----------------------------------------------------------------------------
module gpf_rem_unit
	import gpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   busy,
	output logic [VALUE_WIDTH:0]   remainder
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [VALUE_WIDTH:0]   rem_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   diff;

	assign shifted = {rem_q[VALUE_WIDTH-1:0], dvd_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			// keep the difference unless it went negative
			rem_q <= diff[VALUE_WIDTH] ? shifted : diff;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

// ===== design/gpf_datapath.sv =====
// ----------------------------------------------------------------------------
// gpf_datapath
// Working registers, square, remainder unit and result register,
// driven by one microcode operation per cycle.
// ----------------------------------------------------------------------------
`include "goldbach_prime_pair_finder_macros.svh"

module gpf_datapath
	import gpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  op_t                    op,
	output status_t                status,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FIELD_WIDTH-1:0] target,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FIELD_WIDTH-1:0] target_echo,
	output logic                   found,
	output logic [FIELD_WIDTH-1:0] smaller_prime,
	output logic [FIELD_WIDTH-1:0] larger_prime
);

	logic [VALUE_WIDTH-1:0]   tgt_q;
	logic [FIELD_WIDTH-1:0]   echo_q;
	logic [VALUE_WIDTH-1:0]   p_q;
	logic [VALUE_WIDTH-1:0]   n_q;
	logic [VALUE_WIDTH-1:0]   d_q;
	logic [2*VALUE_WIDTH-1:0] sq_q;
	logic                     phase_q;
	logic [VALUE_WIDTH-1:0]   q_val;
	logic                     div_start;
	logic                     div_busy;
	logic [VALUE_WIDTH:0]     rem;

	logic                   out_valid_q;
	logic                   found_q;
	logic [FIELD_WIDTH-1:0] echo_out_q;
	logic [FIELD_WIDTH-1:0] small_q;
	logic [FIELD_WIDTH-1:0] large_q;

	assign in_ready  = (op == OP_LOAD_IN);
	assign q_val     = tgt_q - p_q;
	assign div_start = (op == OP_DIV_START);

	gpf_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.remainder (rem)
	);

	always_comb begin
		status.in_valid  = in_valid;
		status.t_odd     = tgt_q[0];
		status.p_gt_half = p_q > (tgt_q >> 1);
		status.n_is2     = (n_q == VALUE_WIDTH'(2));
		status.n_bad     = (n_q[VALUE_WIDTH-1:1] == '0) || !n_q[0];
		status.sq_gt_n   = sq_q > (2*VALUE_WIDTH)'(n_q);
		status.div_busy  = div_busy;
		status.rem_zero  = (rem == '0);
		status.phase     = phase_q;
		status.out_full  = out_valid_q;
	end

	// working registers: payload only
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD_IN: begin
				if (in_valid) begin
					tgt_q  <= VALUE_WIDTH'(target);
					echo_q <= target;
				end
			end
			OP_P_INIT:   p_q  <= VALUE_WIDTH'(2);
			OP_P_INC:    p_q  <= p_q + 1'b1;
			OP_N_FROM_P: begin
				n_q     <= p_q;
				phase_q <= 1'b0;
			end
			OP_N_FROM_Q: begin
				n_q     <= q_val;
				phase_q <= 1'b1;
			end
			OP_D_INIT:   d_q  <= VALUE_WIDTH'(3);
			OP_D_ADD2:   d_q  <= d_q + VALUE_WIDTH'(2);
			OP_SQ_CALC:  sq_q <= d_q * d_q;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_POST_FOUND || op == OP_POST_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_POST_FOUND) begin
			found_q    <= 1'b1;
			echo_out_q <= echo_q;
			small_q    <= FIELD_WIDTH'(p_q);
			large_q    <= FIELD_WIDTH'(q_val);
		end else if (op == OP_POST_NONE) begin
			found_q    <= 1'b0;
			echo_out_q <= echo_q;
			small_q    <= '0;
			large_q    <= '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign target_echo   = echo_out_q;
	assign found         = found_q;
	assign smaller_prime = small_q;
	assign larger_prime  = large_q;

	`GPF_ASSERT_IMP(a_post_slot_free, op == OP_POST_FOUND || op == OP_POST_NONE, !out_valid_q)
	`GPF_ASSERT_IMP(a_div_idle_start, div_start, !div_busy)
	`GPF_ASSERT_IMP(a_no_pair_zero, out_valid_q && !found_q, small_q == '0 && large_q == '0)
	`GPF_ASSERT_NXT(a_pair_ordered, op == OP_POST_FOUND, small_q <= large_q)

endmodule

// ===== design/gpf_sequencer.sv =====
// ----------------------------------------------------------------------------
// gpf_sequencer
// Microprogram ROM and step counter with conditional jumps.
// ----------------------------------------------------------------------------
module gpf_sequencer
	import gpf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output op_t     op
);

	localparam logic [UPC_W-1:0] S_IDLE   = UPC_W'(0);
	localparam logic [UPC_W-1:0] S_PLOOP  = UPC_W'(2);
	localparam logic [UPC_W-1:0] S_TEST   = UPC_W'(4);
	localparam logic [UPC_W-1:0] S_DLOOP  = UPC_W'(6);
	localparam logic [UPC_W-1:0] S_DWAIT  = UPC_W'(9);
	localparam logic [UPC_W-1:0] S_PRIME  = UPC_W'(12);
	localparam logic [UPC_W-1:0] S_COMPOS = UPC_W'(14);
	localparam logic [UPC_W-1:0] S_FOUND  = UPC_W'(15);
	localparam logic [UPC_W-1:0] S_NONE   = UPC_W'(17);

	function automatic ucode_t urom(input logic [UPC_W-1:0] a);
		ucode_t w;
		case (a)
			5'd0:  w = '{OP_LOAD_IN,    C_NO_IN,     S_IDLE};
			5'd1:  w = '{OP_P_INIT,     C_T_ODD,     S_NONE};
			5'd2:  w = '{OP_NOP,        C_P_GT_HALF, S_NONE};
			5'd3:  w = '{OP_N_FROM_P,   C_NEVER,     S_IDLE};
			5'd4:  w = '{OP_D_INIT,     C_N_IS2,     S_PRIME};
			5'd5:  w = '{OP_NOP,        C_N_BAD,     S_COMPOS};
			5'd6:  w = '{OP_SQ_CALC,    C_NEVER,     S_IDLE};
			5'd7:  w = '{OP_NOP,        C_SQ_GT_N,   S_PRIME};
			5'd8:  w = '{OP_DIV_START,  C_NEVER,     S_IDLE};
			5'd9:  w = '{OP_NOP,        C_DIV_BUSY,  S_DWAIT};
			5'd10: w = '{OP_D_ADD2,     C_REM_ZERO,  S_COMPOS};
			5'd11: w = '{OP_NOP,        C_ALWAYS,    S_DLOOP};
			// phase is still the old one here: set means q was just tested
			5'd12: w = '{OP_N_FROM_Q,   C_PHASE,     S_FOUND};
			5'd13: w = '{OP_NOP,        C_ALWAYS,    S_TEST};
			5'd14: w = '{OP_P_INC,      C_ALWAYS,    S_PLOOP};
			5'd15: w = '{OP_NOP,        C_OUT_FULL,  S_FOUND};
			5'd16: w = '{OP_POST_FOUND, C_ALWAYS,    S_IDLE};
			5'd17: w = '{OP_NOP,        C_OUT_FULL,  S_NONE};
			5'd18: w = '{OP_POST_NONE,  C_ALWAYS,    S_IDLE};
			default: w = '{OP_NOP,      C_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	logic [UPC_W-1:0] upc_q;
	ucode_t           uw;
	logic             take;

	assign uw = urom(upc_q);
	assign op = uw.op;

	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !status.in_valid;
			C_T_ODD:     take = status.t_odd;
			C_P_GT_HALF: take = status.p_gt_half;
			C_N_IS2:     take = status.n_is2;
			C_N_BAD:     take = status.n_bad;
			C_SQ_GT_N:   take = status.sq_gt_n;
			C_DIV_BUSY:  take = status.div_busy;
			C_REM_ZERO:  take = status.rem_zero;
			C_PHASE:     take = status.phase;
			C_OUT_FULL:  take = status.out_full;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= take ? uw.jump : upc_q + 1'b1;
		end
	end

endmodule

// ===== design/goldbach_prime_pair_finder.sv =====
// ----------------------------------------------------------------------------
// goldbach_prime_pair_finder
// Splits an even target into the prime pair with the smallest p.
// ----------------------------------------------------------------------------
// One request in, one result out. A microprogram walks p upward from 2 and
// tests p and then target - p by trial division with odd divisors from 3
// while d*d <= n. Odd targets skip the search. Each trial divisor goes
// through the shared remainder unit, which retires one dividend bit per
// cycle; the total per request is the sum of those trials over every p
// visited and so grows with the target. One request is worked at a time;
// the next is taken as soon as the result is loaded into the output
// register, even if that result is not yet taken.
// ----------------------------------------------------------------------------
module goldbach_prime_pair_finder
	import gpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FIELD_WIDTH-1:0] target,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FIELD_WIDTH-1:0] target_echo,
	output logic                   found,
	output logic [FIELD_WIDTH-1:0] smaller_prime,
	output logic [FIELD_WIDTH-1:0] larger_prime
);

	op_t     op;
	status_t status;

	gpf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	gpf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.status        (status),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target        (target),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.target_echo   (target_echo),
		.found         (found),
		.smaller_prime (smaller_prime),
		.larger_prime  (larger_prime)
	);

endmodule

// ===== sim/goldbach_prime_pair_finder_tb.sv =====
// ----------------------------------------------------------------------------
// goldbach_prime_pair_finder_tb
// Self-checking bench for the prime pair finder. A table of directed targets
// covers the edge values, odd targets and targets with no pair. It is followed
// by random targets under three idle profiles, a long output stall and a
// drain pause. A trial-division model predicts the untyped rows and all
// random targets, and results are checked in order.
// ----------------------------------------------------------------------------
module goldbach_prime_pair_finder_tb;
	import gpf_pkg::*;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] target_echo;
		logic                   found;
		logic [FIELD_WIDTH-1:0] smaller_prime;
		logic [FIELD_WIDTH-1:0] larger_prime;
	} split_t;

	// typed = 1: the row carries its own expected pair
	typedef struct packed {
		logic [FIELD_WIDTH-1:0] target;
		logic                   typed;
		logic                   found;
		logic [FIELD_WIDTH-1:0] p;
		logic [FIELD_WIDTH-1:0] q;
	} probe_t;

	localparam int NUM_PROBES = 22;
	localparam int HOLD_CYCLES = 3000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [FIELD_WIDTH-1:0] target;
	logic                   out_valid;
	logic                   out_ready;
	logic [FIELD_WIDTH-1:0] target_echo;
	logic                   found;
	logic [FIELD_WIDTH-1:0] smaller_prime;
	logic [FIELD_WIDTH-1:0] larger_prime;

	split_t expected_pairs [$];
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	bit     hold_req = 1'b0;
	int     stall_left = 0;
	int     requests_sent = 0;
	int     results_seen = 0;
	int     pairs_found = 0;
	int     no_pair = 0;
	int     widest_p = 0;
	int     mismatches = 0;

	probe_t probes [NUM_PROBES] = '{
		'{16'd0,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd2,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd4,     1'b1, 1'b1, 16'd2, 16'd2},
		'{16'd6,     1'b1, 1'b1, 16'd3, 16'd3},
		'{16'd8,     1'b1, 1'b1, 16'd3, 16'd5},
		'{16'd1,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd3,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd65535, 1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd21845, 1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd10,    1'b1, 1'b1, 16'd3, 16'd7},
		'{16'd12,    1'b1, 1'b1, 16'd5, 16'd7},
		'{16'd100,   1'b1, 1'b1, 16'd3, 16'd97},
		'{16'd16,    1'b1, 1'b1, 16'd3, 16'd13},
		'{16'd9,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd5,     1'b1, 1'b0, 16'd0, 16'd0},
		'{16'd98,    1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd128,   1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd1022,  1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd32768, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd43690, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd65534, 1'b0, 1'b0, 16'd0, 16'd0},
		'{16'd65532, 1'b0, 1'b0, 16'd0, 16'd0}
	};

	goldbach_prime_pair_finder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target       (target),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target_echo  (target_echo),
		.found        (found),
		.smaller_prime(smaller_prime),
		.larger_prime (larger_prime)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("goldbach_prime_pair_finder verification failed");
		$finish;
	end

	function automatic bit is_prime_trial(longint unsigned n);
		longint unsigned d;
		if (n == 2)
			return 1'b1;
		if (n < 2 || n[0] == 1'b0)
			return 1'b0;
		for (d = 3; d * d <= n; d += 2)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// smallest prime p with target - p also prime, searched on the low VALUE_WIDTH bits
	function automatic split_t goldbach_split(logic [FIELD_WIDTH-1:0] t);
		split_t          r;
		longint unsigned w;
		longint unsigned p;
		r = '{t, 1'b0, '0, '0};
		w = longint'(t) & ((64'd1 << VALUE_WIDTH) - 1);
		if (w[0] == 1'b0) begin
			for (p = 2; p <= w / 2; p++) begin
				if (is_prime_trial(p) && is_prime_trial(w - p)) begin
					r.found = 1'b1;
					r.smaller_prime = FIELD_WIDTH'(p);
					r.larger_prime = FIELD_WIDTH'(w - p);
					break;
				end
			end
		end
		return r;
	endfunction

	// half are small even targets; wide ones are slow, odd ones cheap
	function automatic logic [FIELD_WIDTH-1:0] draw_target();
		logic [FIELD_WIDTH-1:0] t;
		int                     bucket;
		bucket = $urandom_range(99);
		t = FIELD_WIDTH'($urandom);
		if (bucket < 50) begin
			t = FIELD_WIDTH'($urandom_range(1023) * 2);
		end else if (bucket < 62) begin
			t[0] = 1'b0;
		end else if (bucket < 94) begin
			t[0] = 1'b1;
		end else begin
			t = '1;
			t = t - FIELD_WIDTH'(2 * $urandom_range(15));
			t[0] = 1'b0;
		end
		return t;
	endfunction

	// call at a rising edge; returns at the edge where the request is taken
	task automatic offer_target(input logic [FIELD_WIDTH-1:0] t, input split_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		target <= t;
		do @(negedge clk); while (!in_ready);
		expected_pairs.push_back(want);
		@(posedge clk);
		requests_sent++;
	endtask

	task automatic run_random(input int count);
		logic [FIELD_WIDTH-1:0] t;
		for (int i = 0; i < count; i++) begin
			t = draw_target();
			offer_target(t, goldbach_split(t));
		end
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// both handshakes are sampled mid-cycle, where they are stable
	always @(negedge clk) begin : check_results
		split_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_seen++;
			if (expected_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: target_echo %0d found %0d p %0d q %0d",
						target_echo, found, smaller_prime, larger_prime);
			end else begin
				want = expected_pairs.pop_front();
				if (want.found) begin
					pairs_found++;
					if (int'(want.smaller_prime) > widest_p)
						widest_p = int'(want.smaller_prime);
				end else begin
					no_pair++;
				end
				if (target_echo !== want.target_echo || found !== want.found ||
						smaller_prime !== want.smaller_prime ||
						larger_prime !== want.larger_prime) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.target_echo, want.found, want.smaller_prime,
							want.larger_prime, target_echo, found, smaller_prime,
							larger_prime);
				end
			end
		end
	end

	initial begin
		split_t want;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		target <= '0;
		out_ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 54;
		foreach (probes[i]) begin
			if (probes[i].typed)
				want = '{probes[i].target, probes[i].found, probes[i].p, probes[i].q};
			else
				want = goldbach_split(probes[i].target);
			offer_target(probes[i].target, want);
		end
		run_random(190);

		// hold input until everything in flight has come back
		wait_all_results();
		send_idle_pct = 54;
		recv_idle_pct = 26;
		run_random(190);

		// stall the output while requests keep coming, so the input backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		for (int i = 0; i < 12; i++) begin
			want = goldbach_split(FIELD_WIDTH'($urandom_range(2, 200) * 2));
			offer_target(want.target_echo, want);
		end
		run_random(180);

		wait_all_results();
		repeat (40) @(posedge clk);
		$display("%0d targets sent, %0d results: %0d split into prime pairs, %0d without a pair",
			requests_sent, results_seen, pairs_found, no_pair);
		$display("largest smallest-prime seen %0d, %0d mismatches", widest_p, mismatches);
		if (mismatches == 0 && expected_pairs.size() == 0)
			$display("goldbach_prime_pair_finder verification clean");
		else
			$display("goldbach_prime_pair_finder verification failed");
		$finish;
	end

endmodule
